### src/tab_pkg.sv
`timescale 1ns / 1ps

package tab_pkg;

  localparam int unsigned CH_W      = 8;
  localparam int unsigned W_W       = 2 * CH_W;          // weight and sum width
  localparam int unsigned NUM_W     = W_W + CH_W;        // blend numerator width
  localparam int unsigned LANES     = 4;                 // red, green, blue, alpha
  localparam int unsigned DIV_STEPS = CH_W;              // one quotient bit per cell
  localparam int unsigned FRONT_STAGES = 2;
  localparam int unsigned LATENCY   = FRONT_STAGES + DIV_STEPS + 1;
  localparam int unsigned CFG_IDX_W = 3;

  localparam int unsigned LANE_R = 0;
  localparam int unsigned LANE_G = 1;
  localparam int unsigned LANE_B = 2;
  localparam int unsigned LANE_A = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEXT_ALPHA    = 3'd0,
    REG_OUTLINE_RED   = 3'd1,
    REG_OUTLINE_GREEN = 3'd2,
    REG_OUTLINE_BLUE  = 3'd3,
    REG_OUTLINE_ALPHA = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] alpha;
  } tab_pix_t;

  // One word moving down the divider row.
  typedef struct packed {
    logic                             vld;
    logic                             blend;
    tab_pix_t                         pix;
    logic [LANES-1:0][NUM_W-1:0]      rem;
    logic [LANES-1:0][W_W-1:0]        den;
    logic [LANES-1:0][CH_W-1:0]       quo;
  } tab_word_t;

endpackage

### src/tab_front.sv
`timescale 1ns / 1ps

module tab_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_vld,
  input  tab_pkg::tab_pix_t       text_pix,
  input  tab_pkg::tab_pix_t       under_pix,
  input  logic [tab_pkg::CH_W-1:0] text_thr,
  input  tab_pkg::tab_pix_t       outline_pix,
  output tab_pkg::tab_word_t      out_word
);
  import tab_pkg::*;

  // stage 1: path select and weights
  logic            s1_vld;
  logic            s1_blend;
  tab_pix_t        s1_pix;
  tab_pix_t        s1_text;
  logic [W_W-1:0]  s1_w1;
  logic [W_W-1:0]  s1_w2;
  logic [CH_W-1:0] s1_ta_cfg;

  logic            pass_text;
  logic            blend;
  logic [CH_W-1:0] oac;
  tab_pix_t        bypass_pix;

  always_comb begin
    pass_text = (text_pix.alpha >= text_thr) || (under_pix.alpha == '0);
    blend     = !pass_text && (text_pix.alpha != '0);
    oac       = (under_pix.alpha < outline_pix.alpha) ? under_pix.alpha : outline_pix.alpha;
    if (pass_text) begin
      bypass_pix = text_pix;
    end else if (under_pix.alpha > outline_pix.alpha) begin
      bypass_pix = outline_pix;
    end else begin
      bypass_pix = under_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= in_vld;
    end
    s1_blend  <= blend;
    s1_pix    <= bypass_pix;
    s1_text   <= text_pix;
    s1_ta_cfg <= text_thr;
    s1_w1     <= W_W'(text_pix.alpha) * W_W'(text_thr);
    s1_w2     <= W_W'(oac) * (W_W'(text_thr) - W_W'(text_pix.alpha));
  end

  // stage 2: numerators and sum
  tab_word_t      word_next;
  logic [W_W-1:0] sum;

  always_comb begin
    sum                    = s1_w1 + s1_w2;
    word_next.vld          = s1_vld;
    word_next.blend        = s1_blend;
    word_next.pix          = s1_pix;
    word_next.rem[LANE_R]  = NUM_W'(s1_text.red) * NUM_W'(s1_w1)
                           + NUM_W'(outline_pix.red) * NUM_W'(s1_w2);
    word_next.rem[LANE_G]  = NUM_W'(s1_text.green) * NUM_W'(s1_w1)
                           + NUM_W'(outline_pix.green) * NUM_W'(s1_w2);
    word_next.rem[LANE_B]  = NUM_W'(s1_text.blue) * NUM_W'(s1_w1)
                           + NUM_W'(outline_pix.blue) * NUM_W'(s1_w2);
    word_next.rem[LANE_A]  = NUM_W'(sum);
    word_next.den[LANE_R]  = sum;
    word_next.den[LANE_G]  = sum;
    word_next.den[LANE_B]  = sum;
    word_next.den[LANE_A]  = W_W'(s1_ta_cfg);
    word_next.quo          = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_word <= '0;
    end else begin
      out_word <= word_next;
    end
  end

endmodule

### src/tab_div_cell.sv
`timescale 1ns / 1ps

module tab_div_cell (
  input  logic               clk,
  input  logic               rst,
  input  tab_pkg::tab_word_t in_word,
  output tab_pkg::tab_word_t out_word
);
  import tab_pkg::*;

  tab_word_t        word_next;
  logic [NUM_W:0]   diff [LANES];
  logic [NUM_W-1:0] rem_sel [LANES];

  // Trial-subtract den<<(DIV_STEPS-1), then shift the remainder up one bit.
  always_comb begin
    word_next = in_word;
    for (int i = 0; i < LANES; i++) begin
      diff[i] = {1'b0, in_word.rem[i]}
              - {2'b00, in_word.den[i], {(DIV_STEPS-1){1'b0}}};
      rem_sel[i] = diff[i][NUM_W] ? in_word.rem[i] : diff[i][NUM_W-1:0];
      word_next.rem[i] = {rem_sel[i][NUM_W-2:0], 1'b0};
      word_next.quo[i] = {in_word.quo[i][CH_W-2:0], ~diff[i][NUM_W]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_word <= '0;
    end else begin
      out_word <= word_next;
    end
  end

endmodule

### src/text_outline_alpha_blend.sv
`timescale 1ns / 1ps
// Throughput: one pixel word per cycle; busy is low whenever rst is low.
// Two front stages, the eight-cell restoring divider row (one quotient bit per
// cell) and the output register set the latency.
// Reset (rst, synchronous) drops every word in flight and loads the register defaults.
// done strobes for one cycle; the receiver cannot stall the output.

module text_outline_alpha_blend (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  output logic                                done,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tab_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tab_pkg::CH_W-1:0]            cfg_data,
  input  logic [tab_pkg::CH_W-1:0]            text_red,
  input  logic [tab_pkg::CH_W-1:0]            text_green,
  input  logic [tab_pkg::CH_W-1:0]            text_blue,
  input  logic [tab_pkg::CH_W-1:0]            text_alpha_in,
  input  logic [tab_pkg::CH_W-1:0]            under_red,
  input  logic [tab_pkg::CH_W-1:0]            under_green,
  input  logic [tab_pkg::CH_W-1:0]            under_blue,
  input  logic [tab_pkg::CH_W-1:0]            under_alpha,
  output logic [tab_pkg::CH_W-1:0]            res_red,
  output logic [tab_pkg::CH_W-1:0]            res_green,
  output logic [tab_pkg::CH_W-1:0]            res_blue,
  output logic [tab_pkg::CH_W-1:0]            res_alpha
);
  import tab_pkg::*;

  // Configuration registers: configured text alpha plus outline color.
  // Writes take effect at the accepting edge, so the channel is always ready.
  tab_pix_t cfg_pix;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_pix.red   <= '0;
      cfg_pix.green <= '0;
      cfg_pix.blue  <= '0;
      cfg_pix.alpha <= '1;  // alpha slot holds the text alpha register
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TEXT_ALPHA:    cfg_pix.alpha <= cfg_data;
        REG_OUTLINE_RED:   cfg_pix.red   <= cfg_data;
        REG_OUTLINE_GREEN: cfg_pix.green <= cfg_data;
        REG_OUTLINE_BLUE:  cfg_pix.blue  <= cfg_data;
        REG_OUTLINE_ALPHA: ;  // held in outline_alpha below
        default: ;            // drop writes to unused indexes
      endcase
    end
  end

  // Outline alpha lives apart from the text alpha slot above.
  logic [CH_W-1:0] outline_alpha;

  always_ff @(posedge clk) begin
    if (rst) begin
      outline_alpha <= '1;
    end else if (cfg_valid && cfg_ready &&
                 (cfg_reg_t'(cfg_index) == REG_OUTLINE_ALPHA)) begin
      outline_alpha <= cfg_data;
    end
  end

  tab_pix_t text_pix;
  tab_pix_t under_pix;

  // The outline color with its own alpha: clamp value, over-opaque compare and
  // the word returned on the over-opaque outline path.
  tab_pix_t outline_pix;

  assign outline_pix = '{red: cfg_pix.red, green: cfg_pix.green,
                         blue: cfg_pix.blue, alpha: outline_alpha};
  assign text_pix    = '{red: text_red, green: text_green,
                         blue: text_blue, alpha: text_alpha_in};
  assign under_pix   = '{red: under_red, green: under_green,
                         blue: under_blue, alpha: under_alpha};

  // The pipeline never stalls; hold busy only while reset is asserted.
  assign busy = rst;

  // Front end: weights, then numerators and sum.
  tab_word_t chain [DIV_STEPS+1];

  tab_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_vld      (start && !busy),
    .text_pix    (text_pix),
    .under_pix   (under_pix),
    .text_thr    (cfg_pix.alpha),
    .outline_pix (outline_pix),
    .out_word    (chain[0])
  );

  // Divider row: each cell retires one quotient bit of all four lanes.
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    tab_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_word  (chain[k]),
      .out_word (chain[k+1])
    );
  end

  // Output register. The quotients never exceed 255 because each numerator
  // is below 256 times its divisor, so no saturation stage is needed.
  tab_word_t last;

  assign last = chain[DIV_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= last.vld;
    end
    if (last.blend) begin
      res_red   <= last.quo[LANE_R];
      res_green <= last.quo[LANE_G];
      res_blue  <= last.quo[LANE_B];
      res_alpha <= last.quo[LANE_A];
    end else begin
      res_red   <= last.pix.red;
      res_green <= last.pix.green;
      res_blue  <= last.pix.blue;
      res_alpha <= last.pix.alpha;
    end
  end

  // Every accepted word comes out through the front, the divider row and the output register, and nothing else.
  a_in_to_out: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(LATENCY) done)
    else $error("accepted word did not complete on time");

  a_out_from_in: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("done without a matching accepted word");

  // Restoring invariant at the end of the row: remainder stays below den<<8.
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (last.vld && last.blend) |->
      ((last.rem[LANE_R] < {last.den[LANE_R], {CH_W{1'b0}}}) &&
       (last.rem[LANE_A] < {last.den[LANE_A], {CH_W{1'b0}}})))
    else $error("divider remainder out of range");

endmodule
